[rtl/core/ecr_pkg.sv]
package ecr_pkg;

  // Fixed-point constants, Q16 unless noted
  localparam logic [16:0] OneQ16    = 17'd65536;
  localparam logic [16:0] SqrtTwo   = 17'd92682;
  localparam logic [14:0] PolyP     = 15'd21469;
  localparam logic [18:0] XMax      = 19'd393216;  // 6.0
  localparam logic [19:0] Hue6Wrap  = 20'd393216;  // 6 sectors of 1.0

  localparam logic signed [23:0] CoefA1 = 24'sd16701;
  localparam logic signed [23:0] CoefA2 = -24'sd18645;
  localparam logic signed [23:0] CoefA3 = 24'sd93154;
  localparam logic signed [23:0] CoefA4 = -24'sd95234;
  localparam logic signed [23:0] CoefA5 = 24'sd69560;

  localparam logic [31:0] CenterReset = 32'd2560;
  localparam logic [47:0] DenomReset  = 48'd142359552;  // 1536 * sqrt2

  localparam int XQBits   = 20;  // quotient bits of the distance divider
  localparam int TQBits   = 17;  // quotient bits of the t divider
  localparam int HSteps   = 5;   // Horner steps
  localparam int ExpTerms = 10;  // series terms of exp(-f)
  localparam int ExpIntLen = 12;

  typedef enum logic {
    REG_CENTER = 1'b0,
    REG_SPREAD = 1'b1
  } cfg_reg_e;

  // distance divider stage
  typedef struct packed {
    logic        neg;
    logic        sat;
    logic        zx;
    logic [67:0] rem;
    logic [XQBits-1:0] q;
  } xdiv_t;

  // t = 2^32 / d divider stage
  typedef struct packed {
    logic        neg;
    logic [21:0] x2;
    logic [17:0] d;
    logic [34:0] rem;
    logic [TQBits-1:0] q;
  } tdiv_t;

  // Horner stage
  typedef struct packed {
    logic               neg;
    logic [21:0]        x2;
    logic [16:0]        t;
    logic signed [23:0] acc;
    logic signed [41:0] p;
  } horn_t;

  // exp(-f) series stage
  typedef struct packed {
    logic               neg;
    logic [16:0]        poly;
    logic [5:0]         n;
    logic [15:0]        f;
    logic [30:0]        term;
    logic signed [31:0] sum;
    logic [46:0]        pr;
    logic [30:0]        v;
    logic [30:0]        q0;
  } exps_t;

  function automatic logic signed [23:0] horner_coef(input int k);
    logic signed [23:0] c;
    case (k)
      0:       c = CoefA4;
      1:       c = CoefA3;
      2:       c = CoefA2;
      3:       c = CoefA1;
      default: c = '0;
    endcase
    return c;
  endfunction

  // exp(-n) in Q16, zero from n = 12 on
  function automatic logic [16:0] exp_neg_int(input logic [5:0] n);
    logic [16:0] r;
    case (n)
      6'd0:    r = 17'd65536;
      6'd1:    r = 17'd24109;
      6'd2:    r = 17'd8869;
      6'd3:    r = 17'd3263;
      6'd4:    r = 17'd1200;
      6'd5:    r = 17'd442;
      6'd6:    r = 17'd162;
      6'd7:    r = 17'd60;
      6'd8:    r = 17'd22;
      6'd9:    r = 17'd8;
      6'd10:   r = 17'd3;
      6'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/elevation_to_color_ramp_core.sv]
// Channel   | Dir | Payload (low bit first)         | Handshake
// s_axis    | in  | tdata: height[31:0]             | tvalid / tready
// m_axis    | out | tdata: red, green, blue (16 ea) | tvalid / tready
// cfg       | in  | idx 0 center_height, 1 spread   | cfg_we_i, no wait
//
// One transaction per cycle sustained while m_axis does not stall. The pipe holds
// 86 register stages, set by the two restoring dividers (one quotient bit per
// stage) and the exp series (three stages per term).
// Reset clears the valid pipe and loads the register reset values.
// Any stall at m_axis freezes every stage at once; s_axis_tready follows it.
module elevation_to_color_ramp_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] height
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [15:0] red, [31:16] green, [47:32] blue
);

  // stage positions in the valid pipe
  localparam int StEntry = 0;
  localparam int StPrep  = 1;
  localparam int StXEnd  = StPrep + ecr_pkg::XQBits;       // last divider stage
  localparam int StX     = StXEnd + 1;
  localparam int StD     = StX + 1;
  localparam int StTEnd  = StD + ecr_pkg::TQBits;
  localparam int StH0    = StTEnd + 1;
  localparam int StHEnd  = StH0 + 2 * ecr_pkg::HSteps;
  localparam int StE0    = StHEnd + 1;
  localparam int StEEnd  = StE0 + 3 * ecr_pkg::ExpTerms;
  localparam int StF1    = StEEnd + 1;
  localparam int StF2    = StF1 + 1;
  localparam int StOut   = StF2 + 1;

  logic signed [31:0] center_q;
  logic [47:0]        denom_q;   // spread * sqrt2, Q16

  logic               adv;
  logic [StOut:0]     vld_q;

  logic signed [32:0] diff_q;
  ecr_pkg::xdiv_t     xd_q [0:ecr_pkg::XQBits];
  logic               xneg_q;
  logic [18:0]        x_q;
  ecr_pkg::tdiv_t     td_q [0:ecr_pkg::TQBits];
  ecr_pkg::horn_t     hn_q [0:2*ecr_pkg::HSteps];
  ecr_pkg::exps_t     ex_q [0:3*ecr_pkg::ExpTerms];
  logic               f1neg_q, f2neg_q;
  logic [16:0]        f1poly_q, e_q;
  logic [16:0]        phi_q;
  logic [15:0]        red_q, green_q, blue_q;

  // config registers; the divisor is formed at write time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= ecr_pkg::CenterReset;
      denom_q  <= ecr_pkg::DenomReset;
    end else if (cfg_we_i) begin
      unique case (ecr_pkg::cfg_reg_e'(cfg_idx_i))
        ecr_pkg::REG_CENTER: center_q <= cfg_wdata_i;
        ecr_pkg::REG_SPREAD: denom_q  <= 48'(cfg_wdata_i[30:0]) * 48'(ecr_pkg::SqrtTwo);
        default: ;
      endcase
    end
  end

  // whole pipe moves together
  assign adv           = !vld_q[StOut] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[StOut];
  assign m_axis_tdata  = {blue_q, green_q, red_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[StOut-1:0], s_axis_tvalid};
    end
  end

  // entry: exact 33-bit difference
  always_ff @(posedge clk_i) begin
    if (adv) begin
      diff_q <= $signed({s_axis_tdata[31], s_axis_tdata}) - $signed({center_q[31], center_q});
    end
  end

  // prep: magnitude, overflow and zero-spread checks
  logic [32:0] mag;
  logic [67:0] num, dtop;
  assign mag  = diff_q[32] ? 33'(~diff_q + 33'sd1) : 33'(diff_q);
  assign num  = {3'b000, mag, 32'd0};
  assign dtop = {denom_q, 20'd0};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      xd_q[0].neg <= diff_q[32];
      xd_q[0].sat <= (denom_q == '0) ? (mag != '0) : (num >= dtop);
      xd_q[0].zx  <= (denom_q == '0) && (mag == '0);
      xd_q[0].rem <= num;
      xd_q[0].q   <= '0;
    end
  end

  // distance divider, one quotient bit per stage
  for (genvar j = 0; j < ecr_pkg::XQBits; j++) begin : g_xdiv
    localparam int B = ecr_pkg::XQBits - 1 - j;
    logic [67:0]    dv;
    logic           ge;
    ecr_pkg::xdiv_t xd_d;
    assign dv = {20'd0, denom_q} << B;
    assign ge = xd_q[j].rem >= dv;
    always_comb begin
      xd_d      = xd_q[j];
      xd_d.rem  = ge ? xd_q[j].rem - dv : xd_q[j].rem;
      xd_d.q[B] = ge;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        xd_q[j+1] <= xd_d;
      end
    end
  end

  // x clamp at 6.0
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xneg_q <= xd_q[ecr_pkg::XQBits].neg;
      if (xd_q[ecr_pkg::XQBits].sat) begin
        x_q <= ecr_pkg::XMax;
      end else if (xd_q[ecr_pkg::XQBits].zx) begin
        x_q <= '0;
      end else if (xd_q[ecr_pkg::XQBits].q > 20'(ecr_pkg::XMax)) begin
        x_q <= ecr_pkg::XMax;
      end else begin
        x_q <= xd_q[ecr_pkg::XQBits].q[18:0];
      end
    end
  end

  // t divisor 1 + p*x, and x^2
  logic [33:0] px;
  logic [37:0] xx;
  assign px = 34'(x_q) * 34'(ecr_pkg::PolyP);
  assign xx = 38'(x_q) * 38'(x_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      td_q[0].neg <= xneg_q;
      td_q[0].x2  <= xx[37:16];
      td_q[0].d   <= 18'(ecr_pkg::OneQ16) + px[33:16];
      td_q[0].rem <= 35'(64'h1_0000_0000);
      td_q[0].q   <= '0;
    end
  end

  // t = 2^32 / d
  for (genvar j = 0; j < ecr_pkg::TQBits; j++) begin : g_tdiv
    localparam int B = ecr_pkg::TQBits - 1 - j;
    logic [34:0]    dv;
    logic           ge;
    ecr_pkg::tdiv_t td_d;
    assign dv = 35'(td_q[j].d) << B;
    assign ge = td_q[j].rem >= dv;
    always_comb begin
      td_d      = td_q[j];
      td_d.rem  = ge ? td_q[j].rem - dv : td_q[j].rem;
      td_d.q[B] = ge;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        td_q[j+1] <= td_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hn_q[0].neg <= td_q[ecr_pkg::TQBits].neg;
      hn_q[0].x2  <= td_q[ecr_pkg::TQBits].x2;
      hn_q[0].t   <= td_q[ecr_pkg::TQBits].q;
      hn_q[0].acc <= ecr_pkg::CoefA5;
      hn_q[0].p   <= '0;
    end
  end

  // Horner: multiply stage, then truncate toward zero and add; the last step clamps to 0..1.0
  for (genvar k = 0; k < ecr_pkg::HSteps; k++) begin : g_horn
    logic signed [41:0] pq, acc_w;
    ecr_pkg::horn_t     hm_d, ha_d;
    assign pq    = (hn_q[2*k+1].p >>> 16)
                 + ((hn_q[2*k+1].p[41] && (hn_q[2*k+1].p[15:0] != '0)) ? 42'sd1 : 42'sd0);
    assign acc_w = pq + 42'(ecr_pkg::horner_coef(k));

    always_comb begin
      hm_d   = hn_q[2*k];
      hm_d.p = 42'(hn_q[2*k].acc) * $signed({25'd0, hn_q[2*k].t});
    end

    always_comb begin
      ha_d = hn_q[2*k+1];
      if (k == ecr_pkg::HSteps - 1) begin
        if (acc_w < 0) begin
          ha_d.acc = '0;
        end else if (acc_w > 42'sd65536) begin
          ha_d.acc = 24'sd65536;
        end else begin
          ha_d.acc = 24'(acc_w);
        end
      end else begin
        ha_d.acc = 24'(acc_w);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        hn_q[2*k+1] <= hm_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        hn_q[2*k+2] <= ha_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ex_q[0].neg  <= hn_q[2*ecr_pkg::HSteps].neg;
      ex_q[0].poly <= hn_q[2*ecr_pkg::HSteps].acc[16:0];
      ex_q[0].n    <= hn_q[2*ecr_pkg::HSteps].x2[21:16];
      ex_q[0].f    <= hn_q[2*ecr_pkg::HSteps].x2[15:0];
      ex_q[0].term <= 31'h4000_0000;
      ex_q[0].sum  <= 32'sh4000_0000;
      ex_q[0].pr   <= '0;
      ex_q[0].v    <= '0;
      ex_q[0].q0   <= '0;
    end
  end

  // exp(-f) series: term*f, /65536 then /k by reciprocal, then fix-up
  for (genvar k = 1; k <= ecr_pkg::ExpTerms; k++) begin : g_exp
    localparam logic [31:0] Recip = 32'(64'd4294967295 / k);
    localparam int A = 3 * k - 3;
    logic [62:0]    vm;
    logic [30:0]    r;
    logic [30:0]    q;
    ecr_pkg::exps_t e1_d, e2_d, e3_d;
    assign vm = 63'(ex_q[A+1].pr[46:16]) * 63'(Recip);
    assign r  = ex_q[A+2].v - 31'(ex_q[A+2].q0 * 31'(k));
    assign q  = (r >= 31'(k)) ? ex_q[A+2].q0 + 31'd1 : ex_q[A+2].q0;

    always_comb begin
      e1_d      = ex_q[A];
      e1_d.pr   = 47'(ex_q[A].term) * 47'(ex_q[A].f);
      e2_d      = ex_q[A+1];
      e2_d.v    = ex_q[A+1].pr[46:16];
      e2_d.q0   = vm[62:32];
      e3_d      = ex_q[A+2];
      e3_d.term = q;
      e3_d.sum  = (k % 2 == 1) ? ex_q[A+2].sum - $signed({1'b0, q})
                               : ex_q[A+2].sum + $signed({1'b0, q});
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ex_q[A+1] <= e1_d;
        ex_q[A+2] <= e2_d;
        ex_q[A+3] <= e3_d;
      end
    end
  end

  // e = exp(-n) * exp(-f)
  logic [16:0] ef;
  logic [33:0] en;
  assign ef = ex_q[3*ecr_pkg::ExpTerms].sum[30:14];
  assign en = 34'(ecr_pkg::exp_neg_int(ex_q[3*ecr_pkg::ExpTerms].n)) * 34'(ef);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1neg_q  <= ex_q[3*ecr_pkg::ExpTerms].neg;
      f1poly_q <= ex_q[3*ecr_pkg::ExpTerms].poly;
      e_q      <= (ex_q[3*ecr_pkg::ExpTerms].n >= 6'(ecr_pkg::ExpIntLen)) ? '0 : en[32:16];
    end
  end

  // phi
  logic [33:0] pe;
  logic [17:0] yv, phi_w;
  assign pe    = 34'(f1poly_q) * 34'(e_q);
  assign yv    = 18'(ecr_pkg::OneQ16) - 18'(pe[33:16]);
  assign phi_w = f1neg_q ? (18'(ecr_pkg::OneQ16) - yv) >> 1 : (18'(ecr_pkg::OneQ16) + yv) >> 1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      phi_q <= phi_w[16:0];
    end
  end

  // hue sector to RGB; hue of 360 wraps to sector 0
  logic [19:0] hue6;
  logic [2:0]  sector;
  logic [15:0] fract, tv, qv;
  assign hue6   = (20'(phi_q) * 20'd6 >= ecr_pkg::Hue6Wrap) ? '0 : 20'(phi_q) * 20'd6;
  assign sector = hue6[18:16];
  assign fract  = hue6[15:0];
  assign tv     = (fract == '0) ? '0 : fract - 16'd1;
  assign qv     = 16'hFFFF - fract;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      unique case (sector)
        3'd0:    begin red_q <= 16'hFFFF; green_q <= tv;       blue_q <= '0;       end
        3'd1:    begin red_q <= qv;       green_q <= 16'hFFFF; blue_q <= '0;       end
        3'd2:    begin red_q <= '0;       green_q <= 16'hFFFF; blue_q <= tv;       end
        3'd3:    begin red_q <= '0;       green_q <= qv;       blue_q <= 16'hFFFF; end
        3'd4:    begin red_q <= tv;       green_q <= '0;       blue_q <= 16'hFFFF; end
        default: begin red_q <= 16'hFFFF; green_q <= '0;       blue_q <= qv;       end
      endcase
    end
  end

  a_x_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StX] |-> x_q <= ecr_pkg::XMax)
    else $error("x above 6.0");

  a_t_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StTEnd] |-> (td_q[ecr_pkg::TQBits].q <= 17'd65536) && (td_q[ecr_pkg::TQBits].q != '0))
    else $error("t out of range");

  a_phi_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StF2] |-> phi_q <= ecr_pkg::OneQ16)
    else $error("phi above 1.0");

  a_full_chan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (red_q == 16'hFFFF) || (green_q == 16'hFFFF) || (blue_q == 16'hFFFF))
    else $error("no channel at full value");

  a_entry_used : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> vld_q[StEntry] == $past(vld_q[StEntry]))
    else $error("pipe moved while stalled");

endmodule

[tb/sv/elevation_to_color_ramp_core_test.sv]
// Checks the elevation-to-color core against a predictor that runs alongside it.
// Elevations are streamed in under several register settings, with random idle
// cycles on both sides and one long output hold-off. Every color that comes out
// is compared with the oldest predicted color still waiting.
module elevation_to_color_ramp_core_test;

  // one pseudo-color, field order as in m_axis_tdata (red lowest)
  typedef struct packed {
    logic [15:0] blue;
    logic [15:0] green;
    logic [15:0] red;
  } rgb_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] height
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // [15:0] red, [31:16] green, [47:32] blue

  elevation_to_color_ramp_core dut (.*);

  // predictor copy of the registers
  logic signed [31:0] mean_q = 32'sd2560;
  logic [30:0]        sigma_q = 31'd1536;

  rgb_t colors_due[$];
  int   mismatches = 0;
  int   colors_seen = 0;
  int   heights_sent = 0;
  int   tx_idle = 0;          // percent of cycles the sender idles
  int   rx_idle = 0;          // percent of cycles the receiver idles
  int   rx_hold = 0;          // cycles of forced output hold-off
  int   quiet_cycles = 0;

  localparam int QuietLimit = 20000;

  initial forever #5 clk_i = ~clk_i;

  // exp(-n) in Q16
  function automatic longint unsigned exp_int_q16(longint unsigned n);
    longint unsigned tab [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
    return (n >= 12) ? 0 : tab[n];
  endfunction

  function automatic rgb_t ramp_color(logic signed [31:0] h);
    longint          d, acc, sum;
    longint unsigned a, denom, x, t, x2, n, f, term, ef, e, prod, y, phi, hue6;
    longint unsigned sector, fract, tv, qv;
    bit              neg;
    rgb_t            c;
    d = longint'(h) - longint'(mean_q);
    neg = d < 0;
    a = neg ? longint'(-d) : d;
    denom = longint'(sigma_q) * 92682;
    if (denom == 0) x = (a == 0) ? 0 : (6 << 16);
    else x = (a << 32) / denom;
    if (x > (6 << 16)) x = 6 << 16;
    t = (64'd1 << 32) / (65536 + ((21469 * x) >> 16));
    acc = 69560;
    acc = (acc * longint'(t)) / 65536 - 95234;
    acc = (acc * longint'(t)) / 65536 + 93154;
    acc = (acc * longint'(t)) / 65536 - 18645;
    acc = (acc * longint'(t)) / 65536 + 16701;
    acc = (acc * longint'(t)) / 65536;
    if (acc < 0) acc = 0;
    if (acc > 65536) acc = 65536;
    // exp(-x*x): integer part from table, fraction by a 10-term series in Q30
    x2 = (x * x) >> 16;
    n = x2 >> 16;
    f = x2 & 16'hFFFF;
    term = 64'd1 << 30;
    sum = 64'sd1 << 30;
    for (int k = 1; k <= 10; k++) begin
      term = (term * f) / (65536 * k);
      if (k % 2) sum -= longint'(term);
      else sum += longint'(term);
    end
    ef = longint'(sum) >> 14;
    e = (n >= 12) ? 0 : (exp_int_q16(n) * ef) >> 16;
    prod = (longint'(acc) * e) >> 16;
    y = 65536 - prod;
    phi = neg ? (65536 - y) >> 1 : (65536 + y) >> 1;
    hue6 = phi * 6;
    if (hue6 >= 6 * 65536) hue6 = 0;   // hue of 360 wraps to red
    sector = hue6 >> 16;
    fract = hue6 & 16'hFFFF;
    tv = (fract * 65535) >> 16;
    qv = ((65536 - fract) * 65535) >> 16;
    case (sector)
      0:       c = '{blue: 16'h0, green: 16'(tv), red: 16'hFFFF};
      1:       c = '{blue: 16'h0, green: 16'hFFFF, red: 16'(qv)};
      2:       c = '{blue: 16'(tv), green: 16'hFFFF, red: 16'h0};
      3:       c = '{blue: 16'hFFFF, green: 16'(qv), red: 16'h0};
      4:       c = '{blue: 16'hFFFF, green: 16'h0, red: 16'(tv)};
      default: c = '{blue: 16'(qv), green: 16'h0, red: 16'hFFFF};
    endcase
    return c;
  endfunction

  // offer one height; valid stays high across back-to-back transactions
  task automatic send_height(logic [31:0] h);
    if ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= h;
    do @(posedge clk_i); while (!s_axis_tready);
    colors_due.push_back(ramp_color(h));
    heights_sent++;
  endtask

  // lower valid and wait until every predicted color has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (colors_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(ecr_pkg::cfg_reg_e idx, logic [31:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ecr_pkg::REG_CENTER) mean_q = value;
    else sigma_q = value[30:0];
  endtask

  // mostly heights within a few deviations of the mean, some anywhere
  function automatic logic [31:0] pick_height();
    longint span, off;
    if ($urandom_range(99) < 25) return $urandom;
    span = longint'(sigma_q) * 4 + 4;
    off = longint'($urandom) % span;
    if ($urandom_range(1)) off = -off;
    return 32'(longint'(mean_q) + off);
  endfunction

  task automatic test_reset_values();
    logic [31:0] pts [$] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                             32'd2560, 32'd2559, 32'd2561, 32'd1024, 32'd4096,
                             32'd2560 + 32'd1536, 32'd2560 - 32'd1536, 32'd20000,
                             32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    foreach (pts[i]) send_height(pts[i]);
  endtask

  task automatic test_zero_spread();
    write_reg(ecr_pkg::REG_SPREAD, 32'd0);
    write_reg(ecr_pkg::REG_CENTER, 32'd100);
    send_height(32'd100);
    send_height(32'd101);
    send_height(32'd99);
    send_height(32'h8000_0000);
    send_height(32'h7FFF_FFFF);
  endtask

  task automatic test_extreme_regs();
    write_reg(ecr_pkg::REG_SPREAD, 32'h7FFF_FFFF);
    write_reg(ecr_pkg::REG_CENTER, 32'h8000_0000);
    send_height(32'h8000_0000);
    send_height(32'h7FFF_FFFF);
    send_height(32'h0);
    write_reg(ecr_pkg::REG_CENTER, 32'h7FFF_FFFF);
    write_reg(ecr_pkg::REG_SPREAD, 32'd1);
    send_height(32'h8000_0000);
    send_height(32'h7FFF_FFFF);
    send_height(32'h7FFF_FFFE);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_height(pick_height());
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin tx_idle = 38; rx_idle = 48; end
        1: begin tx_idle = 48; rx_idle = 38; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      for (int s = 0; s < 4; s++) begin
        write_reg(ecr_pkg::REG_CENTER, $urandom);
        if (s == 0) write_reg(ecr_pkg::REG_SPREAD, $urandom_range(1, 16));
        else if (s == 1) write_reg(ecr_pkg::REG_SPREAD, $urandom & 32'h7FFF_FFFF);
        else write_reg(ecr_pkg::REG_SPREAD, $urandom_range(1, 1 << (2 * s + 8)));
        random_phase(125);
      end
    end
  endtask

  // receiver stalls long enough for the pipe to fill and back up the input
  task automatic test_backpressure();
    drain();
    tx_idle = 0;
    rx_idle = 20;
    rx_hold = 400;
    random_phase(200);
  endtask

  // receive side: check each color, then choose next ready
  always @(posedge clk_i) begin
    rgb_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready || m_axis_tvalid && m_axis_tready) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        colors_seen++;
        if (colors_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected color %h", $time, got);
        end else begin
          want = colors_due.pop_front();
          if (got.red !== want.red)
            $display("%0t: red expected %h got %h", $time, want.red, got.red);
          if (got.green !== want.green)
            $display("%0t: green expected %h got %h", $time, want.green, got.green);
          if (got.blue !== want.blue)
            $display("%0t: blue expected %h got %h", $time, want.blue, got.blue);
          if (got !== want) mismatches++;
        end
      end
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: timeout, %0d colors outstanding", $time, colors_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_zero_spread();
    test_extreme_regs();
    test_random_settings();
    test_backpressure();
    drain();
    $display("Sent %0d heights over 16 register settings, checked %0d colors.",
             heights_sent, colors_seen);
    $display("Covered zero and extreme spread, extreme means, idle mixes, long hold-off.");
    if (mismatches == 0 && colors_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[elevation_to_color_ramp_core.f]
rtl/core/ecr_pkg.sv
rtl/core/elevation_to_color_ramp_core.sv
tb/sv/elevation_to_color_ramp_core_test.sv
